[src/uv_disparity_histogram_assert.svh]
// Assertion macros for the U/V disparity histogram block.
`ifndef UV_DISPARITY_HISTOGRAM_ASSERT_SVH
`define UV_DISPARITY_HISTOGRAM_ASSERT_SVH
`ifndef ASSERT_OFF
`define UVDH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("uvdh: implication check failed");
`define UVDH_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("uvdh: next-cycle check failed");
`else
`define UVDH_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define UVDH_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[src/uvdh_pkg.sv]
`timescale 1ns / 1ps

package uvdh_pkg;

    localparam int KIND_W    = 2;
    localparam int ROW_W     = 9;
    localparam int COL_W     = 10;
    localparam int DISP_W    = 8;
    localparam int COUNT_W   = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 8;

    localparam logic [KIND_W-1:0] REQ_ACCUM = 2'd0;
    localparam logic [KIND_W-1:0] REQ_RD_V  = 2'd1;
    localparam logic [KIND_W-1:0] REQ_RD_U  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DISP_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISP_HIGH = 1'b1;

    localparam logic [DISP_W-1:0]  DISP_LOW_RST  = 8'd10;
    localparam logic [DISP_W-1:0]  DISP_HIGH_RST = 8'd245;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = 8'hFF;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic capture;
        logic rd_issue;
        logic commit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic clr_done;
        logic is_read;
        logic slot_free;
    } t_dp_status;

endpackage

[src/uvdh_if.sv]
`timescale 1ns / 1ps

interface uvdh_req_if import uvdh_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   req_type;
    logic [ROW_W-1:0]    pixel_row;
    logic [COL_W-1:0]    pixel_col;
    logic [DISP_W-1:0]   disparity;

    modport source (output valid, output req_type, output pixel_row,
                    output pixel_col, output disparity, input ready);
    modport sink   (input valid, input req_type, input pixel_row,
                    input pixel_col, input disparity, output ready);
endinterface

interface uvdh_rsp_if import uvdh_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [COUNT_W-1:0]  bin_count;
    logic                bin_saturated;

    modport source (output valid, output bin_count, output bin_saturated, input ready);
    modport sink   (input valid, input bin_count, input bin_saturated, output ready);
endinterface

interface uvdh_cfg_if import uvdh_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DAT_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[src/uvdh_ram.sv]
`timescale 1ns / 1ps

module uvdh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/uvdh_ctrl.sv]
`timescale 1ns / 1ps

module uvdh_ctrl import uvdh_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    output logic       o_req_ready,
    input  t_dp_status i_sts,
    output t_ctrl_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (!i_sts.is_read || i_sts.slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_req_ready = 1'b0;
        o_cmd       = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
            end
            ST_IDLE: begin
                o_req_ready   = 1'b1;
                o_cmd.capture = i_req_valid;
            end
            ST_READ: begin
                o_cmd.rd_issue = 1'b1;
            end
            ST_UPDATE: begin
                o_cmd.commit = !i_sts.is_read || i_sts.slot_free;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

endmodule

[src/uvdh_datapath.sv]
`timescale 1ns / 1ps

module uvdh_datapath import uvdh_pkg::*; #(
    parameter int MAX_ROWS  = 512,
    parameter int MAX_COLS  = 1024,
    parameter int DISP_BINS = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ctrl_cmd            i_cmd,
    output t_dp_status           o_sts,
    input  logic [KIND_W-1:0]    i_req_type,
    input  logic [ROW_W-1:0]     i_pixel_row,
    input  logic [COL_W-1:0]     i_pixel_col,
    input  logic [DISP_W-1:0]    i_disparity,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output logic                 o_rsp_valid,
    input  logic                 i_rsp_ready,
    output logic [COUNT_W-1:0]   o_bin_count,
    output logic                 o_bin_saturated
);

    localparam int V_DEPTH   = MAX_ROWS * DISP_BINS;
    localparam int U_DEPTH   = MAX_COLS * DISP_BINS;
    localparam int CLR_DEPTH = (V_DEPTH > U_DEPTH) ? V_DEPTH : U_DEPTH;
    localparam int VAW       = $clog2(V_DEPTH);
    localparam int UAW       = $clog2(U_DEPTH);
    localparam int CAW       = $clog2(CLR_DEPTH);

    logic [KIND_W-1:0]  r_req_type;
    logic [ROW_W-1:0]   r_row;
    logic [COL_W-1:0]   r_col;
    logic [DISP_W-1:0]  r_disp;
    logic [DISP_W-1:0]  r_disp_low;
    logic [DISP_W-1:0]  r_disp_high;
    logic [CAW-1:0]     r_clr_cnt;
    logic               r_rsp_valid;
    logic [COUNT_W-1:0] r_rsp_count;

    logic               row_ok;
    logic               col_ok;
    logic               disp_ok;
    logic               band_ok;
    logic               is_accum;
    logic               is_read;
    logic               slot_free;
    logic [VAW-1:0]     v_addr;
    logic [UAW-1:0]     u_addr;
    logic               v_we;
    logic               u_we;
    logic [VAW-1:0]     v_waddr;
    logic [UAW-1:0]     u_waddr;
    logic [COUNT_W-1:0] v_wdata;
    logic [COUNT_W-1:0] u_wdata;
    logic [COUNT_W-1:0] v_rdata;
    logic [COUNT_W-1:0] u_rdata;
    logic [COUNT_W-1:0] v_inc;
    logic [COUNT_W-1:0] u_inc;
    logic [COUNT_W-1:0] sel_count;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req_type <= i_req_type;
            r_row      <= i_pixel_row;
            r_col      <= i_pixel_col;
            r_disp     <= i_disparity;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disp_low  <= DISP_LOW_RST;
            r_disp_high <= DISP_HIGH_RST;
            r_clr_cnt   <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_index == CFG_DISP_LOW) begin
                r_disp_low <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == CFG_DISP_HIGH) begin
                r_disp_high <= i_cfg_data;
            end
            if (i_cmd.clr_step) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (i_cmd.commit && is_read) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && is_read) begin
            r_rsp_count <= sel_count;
        end
    end

    assign row_ok    = int'(r_row) < MAX_ROWS;
    assign col_ok    = int'(r_col) < MAX_COLS;
    assign disp_ok   = int'(r_disp) < DISP_BINS;
    assign band_ok   = (r_disp >= r_disp_low) && (r_disp <= r_disp_high);
    assign is_accum  = r_req_type == REQ_ACCUM;
    assign is_read   = (r_req_type == REQ_RD_V) || (r_req_type == REQ_RD_U);
    assign slot_free = !r_rsp_valid || i_rsp_ready;

    assign v_addr = VAW'(int'(r_row) * DISP_BINS + int'(r_disp));
    assign u_addr = UAW'(int'(r_col) * DISP_BINS + int'(r_disp));

    assign v_inc = (v_rdata == COUNT_MAX) ? COUNT_MAX : v_rdata + 1'b1;
    assign u_inc = (u_rdata == COUNT_MAX) ? COUNT_MAX : u_rdata + 1'b1;

    always_comb begin
        if (i_cmd.clr_step) begin
            v_we    = int'(r_clr_cnt) < V_DEPTH;
            u_we    = int'(r_clr_cnt) < U_DEPTH;
            v_waddr = VAW'(r_clr_cnt);
            u_waddr = UAW'(r_clr_cnt);
            v_wdata = '0;
            u_wdata = '0;
        end else begin
            v_we    = i_cmd.commit && is_accum && disp_ok && band_ok && row_ok;
            u_we    = i_cmd.commit && is_accum && disp_ok && band_ok && col_ok;
            v_waddr = v_addr;
            u_waddr = u_addr;
            v_wdata = v_inc;
            u_wdata = u_inc;
        end
    end

    always_comb begin
        sel_count = '0;
        if (r_req_type == REQ_RD_V && disp_ok && row_ok) begin
            sel_count = v_rdata;
        end else if (r_req_type == REQ_RD_U && disp_ok && col_ok) begin
            sel_count = u_rdata;
        end
    end

    uvdh_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (V_DEPTH)
    ) u_v_ram (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr (v_waddr),
        .i_wdata (v_wdata),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (v_addr),
        .o_rdata (v_rdata)
    );

    uvdh_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (U_DEPTH)
    ) u_u_ram (
        .i_clk   (i_clk),
        .i_we    (u_we),
        .i_waddr (u_waddr),
        .i_wdata (u_wdata),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (u_addr),
        .o_rdata (u_rdata)
    );

    assign o_sts.clr_done  = int'(r_clr_cnt) == CLR_DEPTH - 1;
    assign o_sts.is_read   = is_read;
    assign o_sts.slot_free = slot_free;

    assign o_rsp_valid     = r_rsp_valid;
    assign o_bin_count     = r_rsp_count;
    assign o_bin_saturated = r_rsp_count == COUNT_MAX;

endmodule

[src/uv_disparity_histogram.sv]
// U/V disparity histogram.
// i_req carries one word per pixel or bin read: req_type accumulate adds the
// pixel to V bin (row, disparity) and U bin (column, disparity) when the
// disparity lies in the configured band; req_type read V or read U returns
// one bin on o_rsp as bin_count and bin_saturated. Other request codes and
// accumulates give no response word.
// i_cfg writes disparity_low (index 0) and disparity_high (index 1); it is
// always ready. The user must write it only while the block is idle; the
// block itself does not enforce this. Each request goes through capture,
// histogram RAM read (the RAM read port is registered), then read-modify-write
// or response load. A read response is valid once the request leaves the last
// step, and the next request is accepted only after that.
// Reset clears both histograms by a pass that writes one entry of each RAM
// per cycle over max(MAX_ROWS, MAX_COLS) * DISP_BINS addresses (262144 at
// default sizes); i_req is not ready during the pass.
// When the receiver stalls, the response word holds in the output register
// and a further read waits in its last step until the register is free.
`timescale 1ns / 1ps
`include "uv_disparity_histogram_assert.svh"

module uv_disparity_histogram import uvdh_pkg::*; #(
    parameter int MAX_ROWS  = 512,
    parameter int MAX_COLS  = 1024,
    parameter int DISP_BINS = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    uvdh_req_if.sink   i_req,
    uvdh_cfg_if.sink   i_cfg,
    uvdh_rsp_if.source o_rsp
);

    t_ctrl_cmd  cmd;
    t_dp_status sts;
    logic       req_ready;

    assign i_req.ready = req_ready;
    assign i_cfg.ready = 1'b1;

    uvdh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    uvdh_datapath #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .DISP_BINS (DISP_BINS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_req_type      (i_req.req_type),
        .i_pixel_row     (i_req.pixel_row),
        .i_pixel_col     (i_req.pixel_col),
        .i_disparity     (i_req.disparity),
        .i_cfg_we        (i_cfg.valid),
        .i_cfg_index     (i_cfg.index),
        .i_cfg_data      (i_cfg.data),
        .o_rsp_valid     (o_rsp.valid),
        .i_rsp_ready     (o_rsp.ready),
        .o_bin_count     (o_rsp.bin_count),
        .o_bin_saturated (o_rsp.bin_saturated)
    );

    `UVDH_ASSERT_IMP(a_no_req_in_clear, i_clk, i_rst_n, cmd.clr_step, !req_ready)
    `UVDH_ASSERT_NXT(a_accept_reads, i_clk, i_rst_n, i_req.valid && req_ready, cmd.rd_issue)
    `UVDH_ASSERT_NXT(a_read_responds, i_clk, i_rst_n, cmd.commit && sts.is_read, o_rsp.valid)

endmodule

[tb/sv/tb_uv_disparity_histogram.sv]
`timescale 1ns / 1ps

module tb_uv_disparity_histogram;
    import uvdh_pkg::*;

    localparam int N_ROWS         = 512;
    localparam int N_COLS         = 1024;
    localparam int N_DISP         = 256;
    localparam int PHASES         = 8;
    localparam int PHASE_WORDS    = 210;
    localparam int IDLE_PCT       = 24;
    localparam int SETTLE_CYCLES  = 12;
    localparam int HOLD_CYCLES    = 250;
    localparam int WATCHDOG_LIMIT = 800000;
    localparam int PRINT_LIMIT    = 40;

    localparam logic [KIND_W-1:0] REQ_UNUSED = 2'd3;

    localparam logic [ROW_W-1:0]  HOT_ROW  = 9'd3;
    localparam logic [COL_W-1:0]  HOT_COL  = 10'd1000;
    localparam logic [DISP_W-1:0] HOT_DISP = 8'd128;

    localparam logic [DISP_W-1:0] BAND_LO [PHASES] = '{10, 0, 128, 200, 0, 255, 100, 10};
    localparam logic [DISP_W-1:0] BAND_HI [PHASES] = '{245, 255, 128, 50, 0, 255, 200, 245};

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               saturated;
    } t_bin_word;

    class hist_bins;
        bit [COUNT_W-1:0] v_map [N_ROWS*N_DISP];
        bit [COUNT_W-1:0] u_map [N_COLS*N_DISP];
        bit [DISP_W-1:0]  band_lo;
        bit [DISP_W-1:0]  band_hi;
        t_bin_word        bins_due [$];
        int               errors;

        function new();
            band_lo = DISP_LOW_RST;
            band_hi = DISP_HIGH_RST;
            errors  = 0;
        endfunction

        function void set_band(logic [DISP_W-1:0] lo, logic [DISP_W-1:0] hi);
            band_lo = lo;
            band_hi = hi;
        endfunction

        function int pending();
            return bins_due.size();
        endfunction

        function bit [COUNT_W-1:0] bumped(bit [COUNT_W-1:0] c);
            return (c == COUNT_MAX) ? c : COUNT_W'(c + 1);
        endfunction

        function void apply_word(logic [KIND_W-1:0] kind, logic [ROW_W-1:0] row,
                                 logic [COL_W-1:0] col, logic [DISP_W-1:0] disp);
            t_bin_word        due;
            bit [COUNT_W-1:0] count;
            count = '0;
            case (kind)
                REQ_ACCUM: begin
                    if (disp < N_DISP && disp >= band_lo && disp <= band_hi) begin
                        if (row < N_ROWS)
                            v_map[row*N_DISP+disp] = bumped(v_map[row*N_DISP+disp]);
                        if (col < N_COLS)
                            u_map[col*N_DISP+disp] = bumped(u_map[col*N_DISP+disp]);
                    end
                end
                REQ_RD_V, REQ_RD_U: begin
                    if (kind == REQ_RD_V && disp < N_DISP && row < N_ROWS)
                        count = v_map[row*N_DISP+disp];
                    if (kind == REQ_RD_U && disp < N_DISP && col < N_COLS)
                        count = u_map[col*N_DISP+disp];
                    due.count     = count;
                    due.saturated = (count == COUNT_MAX);
                    bins_due.push_back(due);
                end
                default: ;
            endcase
        endfunction

        task report(string what);
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("%0t: %s", $time, what);
        endtask

        task check_bin(logic [COUNT_W-1:0] count, logic saturated);
            t_bin_word due;
            if (bins_due.size() == 0) begin
                report($sformatf("unexpected word count=%0d saturated=%0b", count, saturated));
                return;
            end
            due = bins_due.pop_front();
            if (count !== due.count)
                report($sformatf("bin_count %0d, want %0d", count, due.count));
            if (saturated !== due.saturated)
                report($sformatf("bin_saturated %0b, want %0b", saturated, due.saturated));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    uvdh_req_if req_bus();
    uvdh_cfg_if cfg_bus();
    uvdh_rsp_if rsp_bus();

    uv_disparity_histogram i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .i_cfg   (cfg_bus),
        .o_rsp   (rsp_bus)
    );

    hist_bins        model;
    logic [DISP_W-1:0] cur_lo;
    logic [DISP_W-1:0] cur_hi;
    bit              sender_steady;
    int              words_seen;
    int              hold_left;
    int              idle_cycles;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic logic [DISP_W-1:0] in_band_disp();
        if (cur_lo <= cur_hi)
            return DISP_W'($urandom_range(cur_hi, cur_lo));
        return DISP_W'($urandom);
    endfunction

    task automatic send_word(input logic [KIND_W-1:0] kind, input logic [ROW_W-1:0] row,
                             input logic [COL_W-1:0] col, input logic [DISP_W-1:0] disp);
        while (!sender_steady && $urandom_range(99) < IDLE_PCT) begin
            req_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_bus.valid     <= 1'b1;
        req_bus.req_type  <= kind;
        req_bus.pixel_row <= row;
        req_bus.pixel_col <= col;
        req_bus.disparity <= disp;
        do @(posedge i_clk); while (!req_bus.ready);
        model.apply_word(kind, row, col, disp);
    endtask

    task automatic settle();
        req_bus.valid <= 1'b0;
        while (model.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_band(input logic [DISP_W-1:0] lo, input logic [DISP_W-1:0] hi);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= CFG_DISP_LOW;
        cfg_bus.data  <= lo;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_bus.index <= CFG_DISP_HIGH;
        cfg_bus.data  <= hi;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        model.set_band(lo, hi);
        cur_lo = lo;
        cur_hi = hi;
    endtask

    // Drain responses; stall at random, with one quiet window and two long hold-offs.
    initial begin
        words_seen = 0;
        hold_left  = 0;
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_bus.valid && rsp_bus.ready) begin
                model.check_bin(rsp_bus.bin_count, rsp_bus.bin_saturated);
                words_seen++;
                if (words_seen == 150 || words_seen == 700)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end else if (words_seen >= 300 && words_seen < 450) begin
                rsp_bus.ready <= 1'b1;
            end else begin
                rsp_bus.ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
                || (cfg_bus.valid && cfg_bus.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("uv_disparity_histogram: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [KIND_W-1:0] kind;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [DISP_W-1:0] disp;
        int                sent;
        int                pick;
        int                aim;

        model         = new();
        idle_cycles   = 0;
        sender_steady = 1'b0;
        cur_lo        = DISP_LOW_RST;
        cur_hi        = DISP_HIGH_RST;
        i_rst_n           <= 1'b0;
        req_bus.valid     <= 1'b0;
        req_bus.req_type  <= REQ_ACCUM;
        req_bus.pixel_row <= '0;
        req_bus.pixel_col <= '0;
        req_bus.disparity <= '0;
        cfg_bus.valid     <= 1'b0;
        cfg_bus.index     <= CFG_DISP_LOW;
        cfg_bus.data      <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // band edges, just outside them, field extremes, unused fields, unused code
        send_word(REQ_ACCUM,  9'd0,   10'd0,    8'd10);
        send_word(REQ_ACCUM,  9'd0,   10'd0,    8'd245);
        send_word(REQ_ACCUM,  9'd0,   10'd0,    8'd9);
        send_word(REQ_ACCUM,  9'd0,   10'd0,    8'd246);
        send_word(REQ_ACCUM,  9'd511, 10'd1023, 8'd0);
        send_word(REQ_ACCUM,  9'd511, 10'd1023, 8'd255);
        send_word(REQ_ACCUM,  9'd511, 10'd1023, 8'd100);
        send_word(REQ_ACCUM,  9'd511, 10'd1023, 8'd100);
        send_word(REQ_RD_V,   9'd0,   10'd1023, 8'd10);
        send_word(REQ_RD_V,   9'd0,   10'd0,    8'd245);
        send_word(REQ_RD_V,   9'd0,   10'd0,    8'd9);
        send_word(REQ_RD_U,   9'd511, 10'd0,    8'd246);
        send_word(REQ_RD_U,   9'd0,   10'd1023, 8'd100);
        send_word(REQ_RD_V,   9'd511, 10'd0,    8'd100);
        send_word(REQ_UNUSED, 9'd511, 10'd1023, 8'd255);
        send_word(REQ_RD_U,   9'd511, 10'd0,    8'd10);
        send_word(REQ_UNUSED, 9'd0,   10'd0,    8'd0);
        send_word(REQ_RD_V,   9'd511, 10'd1023, 8'd255);
        send_word(REQ_RD_U,   9'd0,   10'd1023, 8'd0);
        send_word(REQ_RD_V,   9'd0,   10'd1023, 8'd255);

        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                settle();
                write_band(BAND_LO[p], BAND_HI[p]);
            end
            sender_steady = (p == 2);
            sent = 0;
            while (sent < PHASE_WORDS) begin
                row  = ROW_W'($urandom);
                col  = COL_W'($urandom);
                disp = DISP_W'($urandom);
                pick = $urandom_range(99);
                aim  = $urandom_range(99);
                if (pick < 55) begin
                    kind = REQ_ACCUM;
                    if (aim < 60) begin
                        row  = HOT_ROW;
                        col  = HOT_COL;
                        disp = HOT_DISP;
                    end else if (aim < 80) begin
                        row  = ROW_W'($urandom_range(7));
                        col  = COL_W'($urandom_range(7));
                        disp = in_band_disp();
                    end
                end else if (pick < 95) begin
                    kind = $urandom_range(1) ? REQ_RD_V : REQ_RD_U;
                    if (aim < 40) begin
                        if (kind == REQ_RD_V)
                            row = HOT_ROW;
                        else
                            col = HOT_COL;
                        disp = HOT_DISP;
                    end else if (aim < 70) begin
                        if (kind == REQ_RD_V)
                            row = ROW_W'($urandom_range(7));
                        else
                            col = COL_W'($urandom_range(7));
                        disp = in_band_disp();
                    end
                end else begin
                    kind = REQ_UNUSED;
                end
                send_word(kind, row, col, disp);
                if (kind != REQ_UNUSED)
                    sent++;
            end
        end

        settle();
        if (model.errors == 0 && model.pending() == 0)
            $display("uv_disparity_histogram: match");
        else
            $display("uv_disparity_histogram: mismatch");
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/uvdh_pkg.sv
src/uvdh_if.sv
src/uvdh_ram.sv
src/uvdh_ctrl.sv
src/uvdh_datapath.sv
src/uv_disparity_histogram.sv
tb/sv/tb_uv_disparity_histogram.sv
